### rtl/urb_pkg.sv
package urb_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int CHAR_BITS_DEF   = 9;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_TX_TIMER = 3'd2,
        OP_RX_CHAR  = 3'd3,
        OP_SPI_DONE = 3'd4,
        OP_BE_READY = 3'd5,
        OP_RX_TIMER = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    localparam logic [2:0] SEL_TXBUF = 3'd0;
    localparam logic [2:0] SEL_RXBUF = 3'd1;
    localparam logic [2:0] SEL_MODE  = 3'd3;
    localparam logic [2:0] SEL_C0    = 3'd4;
    localparam logic [2:0] SEL_C1    = 3'd5;

    localparam logic [2:0] SMD_MASK = 3'd7;
    localparam logic [2:0] SMD_SYNC = 3'd1;
    localparam int C0_TXEPT = 3;
    localparam int C1_TE    = 0;
    localparam int C1_TI    = 1;
    localparam int C1_RE    = 2;
    localparam int C1_RI    = 3;
    localparam int C1_IRS   = 4;

    localparam logic [7:0] C0_RESET = 8'h08;
    localparam logic [7:0] C1_RESET = 8'h02;

    typedef struct packed {
        op_t         op;
        logic [2:0]  sel;
        logic [15:0] wdata;
        logic [8:0]  rch;
        logic [7:0]  sbyte;
    } cmd_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic        tx_irq;
        logic        rx_irq;
        logic        out_char_valid;
        logic [8:0]  out_char;
        logic        spi_start;
        logic [7:0]  spi_byte;
        logic        tx_timer_arm;
        logic        tx_retry;
        logic        rx_start;
        logic        rx_pause;
        logic        backend_tx_start;
    } res_t;

endpackage

### rtl/urb_front.sv
module urb_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [39:0]        s_tdata,
    output logic               q_valid,
    input  logic               q_ready,
    output urb_pkg::cmd_t      q_cmd
);
    // two-entry queue of classified commands
    urb_pkg::cmd_t ent_reg [2];
    logic          rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0]    cnt_reg, cnt_next;
    urb_pkg::cmd_t cmd;
    logic          push, pop;

    always_comb begin
        cmd.op    = urb_pkg::op_t'(s_tdata[2:0]);
        cmd.sel   = s_tdata[5:3];
        cmd.wdata = s_tdata[21:6];
        cmd.rch   = s_tdata[30:22];
        cmd.sbyte = s_tdata[38:31];
        if (s_tdata[2:0] == urb_pkg::OP_WRITE &&
            !(s_tdata[5:3] == urb_pkg::SEL_TXBUF || s_tdata[5:3] == urb_pkg::SEL_MODE ||
              s_tdata[5:3] == urb_pkg::SEL_C0 || s_tdata[5:3] == urb_pkg::SEL_C1)) begin
            cmd.op = urb_pkg::OP_NONE;
        end
    end

    assign s_tready = cnt_reg != 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_cmd    = ent_reg[rd_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;
    assign rd_next  = rd_reg ^ pop;
    assign wr_next  = wr_reg ^ push;
    assign cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_reg] <= cmd;
        end
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> !s_tready) else $error("accept while full");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0) |-> (rd_reg == wr_reg)) else $error("pointer skew");
`endif
endmodule

### rtl/urb_back.sv
module urb_back #(
    parameter int QUEUE_DEPTH = urb_pkg::QUEUE_DEPTH_DEF,
    parameter int CHAR_BITS   = urb_pkg::CHAR_BITS_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    output logic          q_ready,
    input  urb_pkg::cmd_t q_cmd,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata
);
    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int PW = AW + 1;
    localparam logic [PW-1:0] SPAN_M1 = PW'(2 * QUEUE_DEPTH - 1);

    logic [7:0]      mode_reg, mode_next, c0_reg, c0_next, c1_reg, c1_next;
    logic [15:0]     txb_reg, txb_next, rxb_reg, rxb_next, sh_reg, sh_next;
    logic [PW-1:0]   wp_reg, wp_next, rp_reg, rp_next, level;
    logic [CHAR_BITS-1:0] q_mem [QUEUE_DEPTH];
    logic            mv_reg;
    urb_pkg::res_t   res, res_reg;
    logic            go, sync, qwr;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == SPAN_M1) ? '0 : p + PW'(1);
    endfunction

    function automatic logic [AW-1:0] ptr_idx(input logic [PW-1:0] p);
        ptr_idx = (p >= PW'(QUEUE_DEPTH)) ? AW'(p - PW'(QUEUE_DEPTH)) : AW'(p);
    endfunction

    assign q_ready = !mv_reg || m_tready;
    assign go      = q_valid && q_ready;
    assign sync    = (mode_reg[2:0] & urb_pkg::SMD_MASK) == urb_pkg::SMD_SYNC;
    assign level   = (wp_reg >= rp_reg) ? wp_reg - rp_reg
                                        : PW'(wp_reg + PW'(2 * QUEUE_DEPTH) - rp_reg);

    always_comb begin
        mode_next = mode_reg; c0_next = c0_reg; c1_next = c1_reg;
        txb_next = txb_reg; rxb_next = rxb_reg; sh_next = sh_reg;
        wp_next = wp_reg; rp_next = rp_reg; qwr = 1'b0;
        res = '0;
        case (q_cmd.op)
            urb_pkg::OP_READ: begin
                case (q_cmd.sel)
                    urb_pkg::SEL_RXBUF: begin
                        res.read_data = rxb_reg;
                        c1_next[urb_pkg::C1_RI] = 1'b0;
                    end
                    urb_pkg::SEL_MODE: res.read_data = {8'd0, mode_reg};
                    urb_pkg::SEL_C0:   res.read_data = {8'd0, c0_reg};
                    urb_pkg::SEL_C1:   res.read_data = {8'd0, c1_reg};
                    default:           res.read_data = '0;
                endcase
            end
            urb_pkg::OP_WRITE: begin
                case (q_cmd.sel)
                    urb_pkg::SEL_TXBUF: begin
                        txb_next = q_cmd.wdata;
                        if (c1_reg[urb_pkg::C1_TE]) begin
                            if (c0_reg[urb_pkg::C0_TXEPT]) begin
                                sh_next = q_cmd.wdata;
                                c0_next[urb_pkg::C0_TXEPT] = 1'b0;
                                if (sync) begin
                                    res.spi_start = 1'b1;
                                    res.spi_byte  = q_cmd.wdata[7:0];
                                end else begin
                                    res.tx_timer_arm = 1'b1;
                                end
                                res.tx_irq = !c1_reg[urb_pkg::C1_IRS];
                            end else begin
                                c1_next[urb_pkg::C1_TI] = 1'b0;
                            end
                        end
                    end
                    urb_pkg::SEL_MODE: mode_next = q_cmd.wdata[7:0];
                    urb_pkg::SEL_C0: begin
                        c0_next = q_cmd.wdata[7:0];
                        c0_next[urb_pkg::C0_TXEPT] = c0_reg[urb_pkg::C0_TXEPT];
                    end
                    urb_pkg::SEL_C1: begin
                        c1_next = q_cmd.wdata[7:0];
                        res.rx_start = !sync && q_cmd.wdata[urb_pkg::C1_RE];
                    end
                    default: ;
                endcase
            end
            urb_pkg::OP_TX_TIMER: begin
                if (level >= PW'(QUEUE_DEPTH)) begin
                    res.tx_retry = 1'b1;
                end else begin
                    qwr = 1'b1;
                    wp_next = ptr_inc(wp_reg);
                    res.backend_tx_start = level == '0;
                    if (c1_reg[urb_pkg::C1_TI]) begin
                        c0_next[urb_pkg::C0_TXEPT] = 1'b1;
                        res.tx_irq = c1_reg[urb_pkg::C1_IRS];
                    end else begin
                        sh_next = txb_reg;
                        c1_next[urb_pkg::C1_TI] = 1'b1;
                        res.tx_irq = !c1_reg[urb_pkg::C1_IRS];
                        res.tx_timer_arm = 1'b1;
                    end
                    if (sync && !c1_reg[urb_pkg::C1_RI]) begin
                        c1_next[urb_pkg::C1_RI] = 1'b1;
                        res.rx_irq = 1'b1;
                    end
                end
            end
            urb_pkg::OP_RX_CHAR: begin
                rxb_next = {7'd0, q_cmd.rch};
                c1_next[urb_pkg::C1_RI] = 1'b1;
                res.rx_irq   = !c1_reg[urb_pkg::C1_RI];
                res.rx_pause = 1'b1;
            end
            urb_pkg::OP_SPI_DONE: begin
                if (c1_reg[urb_pkg::C1_RE]) begin
                    rxb_next = {8'd0, q_cmd.sbyte};
                    c1_next[urb_pkg::C1_RI] = 1'b1;
                    res.rx_irq = !c1_reg[urb_pkg::C1_RI];
                end
                if (c1_reg[urb_pkg::C1_TI]) begin
                    c0_next[urb_pkg::C0_TXEPT] = 1'b1;
                    res.tx_irq = c1_reg[urb_pkg::C1_IRS];
                end else begin
                    sh_next = txb_reg;
                    c1_next[urb_pkg::C1_TI] = 1'b1;
                    res.tx_irq = !c1_reg[urb_pkg::C1_IRS];
                    res.spi_start = 1'b1;
                    res.spi_byte  = txb_reg[7:0];
                end
            end
            urb_pkg::OP_BE_READY: begin
                if (rp_reg != wp_reg) begin
                    res.out_char_valid = 1'b1;
                    res.out_char = 9'(q_mem[ptr_idx(rp_reg)]);
                    rp_next = ptr_inc(rp_reg);
                end
            end
            urb_pkg::OP_RX_TIMER: res.rx_start = !sync && c1_reg[urb_pkg::C1_RE];
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (go && qwr) begin
            q_mem[ptr_idx(wp_reg)] <= sh_reg[CHAR_BITS-1:0];
        end
        if (go) begin
            res_reg <= res;
        end
        if (!aresetn) begin
            mode_reg <= '0; c0_reg <= urb_pkg::C0_RESET; c1_reg <= urb_pkg::C1_RESET;
            txb_reg <= '0; rxb_reg <= '0; sh_reg <= '0;
            wp_reg <= '0; rp_reg <= '0; mv_reg <= 1'b0;
        end else begin
            if (go) begin
                mode_reg <= mode_next; c0_reg <= c0_next; c1_reg <= c1_next;
                txb_reg <= txb_next; rxb_reg <= rxb_next; sh_reg <= sh_next;
                wp_reg <= wp_next; rp_reg <= rp_next;
            end
            mv_reg <= go || (mv_reg && !m_tready);
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = {6'd0, res_reg.backend_tx_start, res_reg.rx_pause, res_reg.rx_start,
                       res_reg.tx_retry, res_reg.tx_timer_arm, res_reg.spi_byte,
                       res_reg.spi_start, res_reg.out_char, res_reg.out_char_valid,
                       res_reg.rx_irq, res_reg.tx_irq, res_reg.read_data};

`ifndef SYNTH
    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        level <= PW'(QUEUE_DEPTH)) else $error("queue level overflow");
    a_retry_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && res.tx_retry) |-> level == PW'(QUEUE_DEPTH)) else $error("bad retry");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !m_tready) |=> $stable(res_reg)) else $error("result changed");
`endif
endmodule

### rtl/uart_register_block.sv
// channel  dir  tdata fields (lsb first)
// s_       in   op[2:0] reg_select[5:3] write_data[21:6] rx_char[30:22] spi_rx_byte[38:31]
// m_       out  read_data tx_irq rx_irq out_char_valid out_char spi_start spi_byte
//               tx_timer_arm tx_retry rx_start rx_pause backend_tx_start
// One beat per cycle sustained while m_tready stays high; each beat passes through the
// command queue and then the result register. Register updates happen in the back end.
// aresetn is synchronous; the output queue contents are not cleared.
// A stalled m_ side fills the two-entry command queue before s_tready drops.
module uart_register_block #(
    parameter int QUEUE_DEPTH = urb_pkg::QUEUE_DEPTH_DEF,
    parameter int CHAR_BITS   = urb_pkg::CHAR_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op, reg_select, write_data, rx_char, spi_rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_data .. backend_tx_start, see above
);
    logic          q_valid, q_ready;
    urb_pkg::cmd_t q_cmd;

    urb_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_cmd
    );

    urb_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .CHAR_BITS(CHAR_BITS)) u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_tvalid, .m_tready, .m_tdata
    );
endmodule

### test/uart_register_block_test.sv
module uart_register_block_test;

    localparam int NUM_RANDOM = 1950;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        urb_pkg::cmd_t cmd;
        bit            typed;
        urb_pkg::res_t res;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    // predicted register file
    logic [7:0]  mode_q, ctl0_q, ctl1_q;
    logic [15:0] txbuf_q, rxbuf_q, shift_q;
    logic [8:0]  line_fifo [8];
    logic [3:0]  wr_ptr, rd_ptr;

    urb_pkg::res_t pending_beats[$];
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   cycles = 0;
    bit   failed = 1'b0;

    uart_register_block i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic bit is_sync();
        return mode_q[2:0] == urb_pkg::SMD_SYNC;
    endfunction

    function automatic void set_rx_full(ref urb_pkg::res_t r);
        if (!ctl1_q[urb_pkg::C1_RI]) begin
            ctl1_q[urb_pkg::C1_RI] = 1'b1;
            r.rx_irq = 1'b1;
        end
    endfunction

    // shift register finished: refill from buffer or go empty
    function automatic void tx_shift_done(ref urb_pkg::res_t r, input bit spi);
        if (ctl1_q[urb_pkg::C1_TI]) begin
            ctl0_q[urb_pkg::C0_TXEPT] = 1'b1;
            if (ctl1_q[urb_pkg::C1_IRS]) r.tx_irq = 1'b1;
        end else begin
            shift_q = txbuf_q;
            ctl1_q[urb_pkg::C1_TI] = 1'b1;
            if (!ctl1_q[urb_pkg::C1_IRS]) r.tx_irq = 1'b1;
            if (spi) begin
                r.spi_start = 1'b1;
                r.spi_byte = shift_q[7:0];
            end else begin
                r.tx_timer_arm = 1'b1;
            end
        end
    endfunction

    function automatic urb_pkg::res_t predict_port(urb_pkg::cmd_t c);
        urb_pkg::res_t r;
        logic [3:0] lvl;
        r = '0;
        case (c.op)
            urb_pkg::OP_READ: begin
                case (c.sel)
                    urb_pkg::SEL_RXBUF: begin
                        ctl1_q[urb_pkg::C1_RI] = 1'b0;
                        r.read_data = rxbuf_q;
                    end
                    urb_pkg::SEL_MODE: r.read_data = {8'h00, mode_q};
                    urb_pkg::SEL_C0:   r.read_data = {8'h00, ctl0_q};
                    urb_pkg::SEL_C1:   r.read_data = {8'h00, ctl1_q};
                    default:  r.read_data = '0;
                endcase
            end
            urb_pkg::OP_WRITE: begin
                case (c.sel)
                    urb_pkg::SEL_TXBUF: begin
                        txbuf_q = c.wdata;
                        if (ctl1_q[urb_pkg::C1_TE]) begin
                            if (ctl0_q[urb_pkg::C0_TXEPT]) begin
                                shift_q = txbuf_q;
                                ctl0_q[urb_pkg::C0_TXEPT] = 1'b0;
                                if (is_sync()) begin
                                    r.spi_start = 1'b1;
                                    r.spi_byte = shift_q[7:0];
                                end else begin
                                    r.tx_timer_arm = 1'b1;
                                end
                                if (!ctl1_q[urb_pkg::C1_IRS]) r.tx_irq = 1'b1;
                            end else begin
                                ctl1_q[urb_pkg::C1_TI] = 1'b0;
                            end
                        end
                    end
                    urb_pkg::SEL_MODE: mode_q = c.wdata[7:0];
                    urb_pkg::SEL_C0: begin
                        ctl0_q = {c.wdata[7:4], ctl0_q[urb_pkg::C0_TXEPT], c.wdata[2:0]};
                    end
                    urb_pkg::SEL_C1: begin
                        ctl1_q = c.wdata[7:0];
                        if (!is_sync() && ctl1_q[urb_pkg::C1_RE]) r.rx_start = 1'b1;
                    end
                    default: ;
                endcase
            end
            urb_pkg::OP_TX_TIMER: begin
                lvl = wr_ptr - rd_ptr;
                if (lvl >= 4'd8) begin
                    r.tx_retry = 1'b1;
                end else begin
                    line_fifo[wr_ptr[2:0]] = shift_q[8:0];
                    wr_ptr = wr_ptr + 4'd1;
                    if (lvl == 4'd0) r.backend_tx_start = 1'b1;
                    tx_shift_done(r, 1'b0);
                    if (is_sync()) set_rx_full(r);
                end
            end
            urb_pkg::OP_RX_CHAR: begin
                rxbuf_q = {7'h00, c.rch};
                set_rx_full(r);
                r.rx_pause = 1'b1;
            end
            urb_pkg::OP_SPI_DONE: begin
                if (ctl1_q[urb_pkg::C1_RE]) begin
                    rxbuf_q = {8'h00, c.sbyte};
                    set_rx_full(r);
                end
                tx_shift_done(r, 1'b1);
            end
            urb_pkg::OP_BE_READY: begin
                if (rd_ptr != wr_ptr) begin
                    r.out_char_valid = 1'b1;
                    r.out_char = line_fifo[rd_ptr[2:0]];
                    rd_ptr = rd_ptr + 4'd1;
                end
            end
            urb_pkg::OP_RX_TIMER: begin
                if (!is_sync() && ctl1_q[urb_pkg::C1_RE]) r.rx_start = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        urb_pkg::res_t e, a;
        if (aresetn && m_tvalid && m_tready) begin
            a = '0;
            a.read_data = m_tdata[15:0];
            a.tx_irq = m_tdata[16];
            a.rx_irq = m_tdata[17];
            a.out_char_valid = m_tdata[18];
            a.out_char = m_tdata[27:19];
            a.spi_start = m_tdata[28];
            a.spi_byte = m_tdata[36:29];
            a.tx_timer_arm = m_tdata[37];
            a.tx_retry = m_tdata[38];
            a.rx_start = m_tdata[39];
            a.rx_pause = m_tdata[40];
            a.backend_tx_start = m_tdata[41];
            if (pending_beats.size() == 0) begin
                $error("unexpected beat %h", m_tdata);
                failed = 1'b1;
            end else begin
                e = pending_beats.pop_front();
                if (a.read_data != e.read_data) begin
                    $error("read_data exp %h got %h", e.read_data, a.read_data);
                    failed = 1'b1;
                end
                if (a.tx_irq != e.tx_irq) begin
                    $error("tx_irq exp %b got %b", e.tx_irq, a.tx_irq);
                    failed = 1'b1;
                end
                if (a.rx_irq != e.rx_irq) begin
                    $error("rx_irq exp %b got %b", e.rx_irq, a.rx_irq);
                    failed = 1'b1;
                end
                if (a.out_char_valid != e.out_char_valid) begin
                    $error("out_char_valid exp %b got %b", e.out_char_valid,
                           a.out_char_valid);
                    failed = 1'b1;
                end
                if (a.out_char != e.out_char) begin
                    $error("out_char exp %h got %h", e.out_char, a.out_char);
                    failed = 1'b1;
                end
                if (a.spi_start != e.spi_start) begin
                    $error("spi_start exp %b got %b", e.spi_start, a.spi_start);
                    failed = 1'b1;
                end
                if (a.spi_byte != e.spi_byte) begin
                    $error("spi_byte exp %h got %h", e.spi_byte, a.spi_byte);
                    failed = 1'b1;
                end
                if (a.tx_timer_arm != e.tx_timer_arm) begin
                    $error("tx_timer_arm exp %b got %b", e.tx_timer_arm, a.tx_timer_arm);
                    failed = 1'b1;
                end
                if (a.tx_retry != e.tx_retry) begin
                    $error("tx_retry exp %b got %b", e.tx_retry, a.tx_retry);
                    failed = 1'b1;
                end
                if (a.rx_start != e.rx_start) begin
                    $error("rx_start exp %b got %b", e.rx_start, a.rx_start);
                    failed = 1'b1;
                end
                if (a.rx_pause != e.rx_pause) begin
                    $error("rx_pause exp %b got %b", e.rx_pause, a.rx_pause);
                    failed = 1'b1;
                end
                if (a.backend_tx_start != e.backend_tx_start) begin
                    $error("backend_tx_start exp %b got %b", e.backend_tx_start,
                           a.backend_tx_start);
                    failed = 1'b1;
                end
            end
        end
    end

    task automatic send_beat(input urb_pkg::cmd_t c, input bit typed,
                             input urb_pkg::res_t typed_res);
        urb_pkg::res_t p;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, c.sbyte, c.rch, c.wdata, c.sel, 3'(c.op)};
        do @(posedge aclk); while (!s_tready);
        p = predict_port(c);
        pending_beats.push_back(typed ? typed_res : p);
    endtask

    function automatic urb_pkg::cmd_t mk(urb_pkg::op_t op, logic [2:0] sel, logic [15:0] wd,
                                         logic [8:0] rch = '0, logic [7:0] sb = '0);
        urb_pkg::cmd_t c;
        c.op = op;
        c.sel = sel;
        c.wdata = wd;
        c.rch = rch;
        c.sbyte = sb;
        return c;
    endfunction

    function automatic urb_pkg::res_t rd_res(logic [15:0] v);
        urb_pkg::res_t r;
        r = '0;
        r.read_data = v;
        return r;
    endfunction

    function automatic urb_pkg::cmd_t random_cmd();
        urb_pkg::cmd_t c;
        int r;
        r = $urandom_range(0, 99);
        c.sel = 3'($urandom_range(0, 7));
        c.wdata = 16'($urandom);
        c.rch = 9'($urandom);
        c.sbyte = 8'($urandom);
        if (r < 18) c.op = urb_pkg::OP_READ;
        else if (r < 40) c.op = urb_pkg::OP_WRITE;
        else if (r < 60) c.op = urb_pkg::OP_TX_TIMER;
        else if (r < 68) c.op = urb_pkg::OP_RX_CHAR;
        else if (r < 77) c.op = urb_pkg::OP_SPI_DONE;
        else if (r < 93) c.op = urb_pkg::OP_BE_READY;
        else if (r < 98) c.op = urb_pkg::OP_RX_TIMER;
        else c.op = urb_pkg::OP_NONE;
        if (c.op == urb_pkg::OP_WRITE) begin
            if ($urandom_range(0, 1)) c.sel = urb_pkg::SEL_TXBUF;
            if (c.sel == urb_pkg::SEL_C1 && $urandom_range(0, 3) != 0)
                c.wdata[urb_pkg::C1_TE] = 1'b1;
            if (c.sel == urb_pkg::SEL_MODE && $urandom_range(0, 1))
                c.wdata[2:0] = urb_pkg::SMD_SYNC;
        end
        return c;
    endfunction

    initial begin
        row_t rows [$];
        urb_pkg::res_t z;
        int n;
        z = '0;
        mode_q = '0;
        ctl0_q = urb_pkg::C0_RESET;
        ctl1_q = urb_pkg::C1_RESET;
        txbuf_q = '0;
        rxbuf_q = '0;
        shift_q = '0;
        wr_ptr = '0;
        rd_ptr = '0;
        foreach (line_fifo[k]) line_fifo[k] = '0;

        rows.push_back('{mk(urb_pkg::OP_READ, urb_pkg::SEL_C0, 16'h0), 1, rd_res(16'h0008)});
        rows.push_back('{mk(urb_pkg::OP_READ, urb_pkg::SEL_C1, 16'h0), 1, rd_res(16'h0002)});
        rows.push_back('{mk(urb_pkg::OP_READ, urb_pkg::SEL_MODE, 16'h0), 1,
                         rd_res(16'h0000)});
        rows.push_back('{mk(urb_pkg::OP_READ, 3'd2, 16'h0), 1, rd_res(16'h0000)});
        rows.push_back('{mk(urb_pkg::OP_READ, 3'd7, 16'h0), 1, rd_res(16'h0000)});
        rows.push_back('{mk(urb_pkg::OP_NONE, 3'd7, 16'hFFFF, 9'h1FF, 8'hFF), 1, z});
        rows.push_back('{mk(urb_pkg::OP_BE_READY, 3'd0, 16'h0), 1, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_TXBUF, 16'hFFFF), 1, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_RXBUF, 16'hFFFF), 1, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, 3'd2, 16'hFFFF), 1, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_C0, 16'h00F7), 1, z});
        rows.push_back('{mk(urb_pkg::OP_READ, urb_pkg::SEL_C0, 16'h0), 1, rd_res(16'h00FF)});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_C1, 16'h0015), 0, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_TXBUF, 16'h1ABC), 0, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_TXBUF, 16'h0055), 0, z});
        for (int k = 0; k < 9; k++)
            rows.push_back('{mk(urb_pkg::OP_TX_TIMER, 3'd0, 16'h0), 0, z});
        rows.push_back('{mk(urb_pkg::OP_BE_READY, 3'd0, 16'h0), 0, z});
        rows.push_back('{mk(urb_pkg::OP_RX_CHAR, 3'd0, 16'h0, 9'h1FF), 0, z});
        rows.push_back('{mk(urb_pkg::OP_READ, urb_pkg::SEL_RXBUF, 16'h0), 0, z});
        rows.push_back('{mk(urb_pkg::OP_RX_TIMER, 3'd0, 16'h0), 0, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_MODE, 16'h00FF), 0, z});
        rows.push_back('{mk(urb_pkg::OP_WRITE, urb_pkg::SEL_MODE, 16'h0001), 0, z});
        rows.push_back('{mk(urb_pkg::OP_SPI_DONE, 3'd0, 16'h0, 9'h0, 8'hFF), 0, z});

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[k]) send_beat(rows[k].cmd, rows[k].typed, rows[k].res);
        for (int k = 0; k < NUM_RANDOM; k++) begin
            n = (k * 4) / NUM_RANDOM;
            send_idle_pct = (n == 1) ? 56 : (n == 3) ? 30 : 0;
            recv_stall_pct = (n == 2) ? 56 : (n == 3) ? 30 : 0;
            send_beat(random_cmd(), 1'b0, z);
        end
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

### files.f
rtl/urb_pkg.sv
rtl/urb_front.sv
rtl/urb_back.sv
rtl/uart_register_block.sv
test/uart_register_block_test.sv
